// ----- rtl/rss_pkg.sv -----
// ----------------------------------------------------------------------------
// rss_pkg
// Shared widths and codes for the request slot scheduler.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned SIZE_W   = 31;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic FUNC_PUT = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_PUT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PUT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_GET_OK    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_GET_EMPTY = 2'd3;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_SLOTS = 1'b1;

  localparam logic [OCC_W-1:0] SLOTS_RESET = 5'd16;

endpackage

// ----- rtl/rss_pick_unit.sv -----
// ----------------------------------------------------------------------------
// rss_pick_unit
// Shared key compare: age or job size of one slot against the current pick.
// ----------------------------------------------------------------------------
module rss_pick_unit import rss_pkg::*; #(
  parameter int unsigned STAMP_BITS = 32
) (
  input  logic                                                  mode_i,
  input  logic                                                  found_i,
  input  logic [STAMP_BITS-1:0]                                 arrival_i,
  input  logic [STAMP_BITS-1:0]                                 stamp_i,
  input  logic [SIZE_W-1:0]                                     size_i,
  input  logic [((STAMP_BITS > SIZE_W) ? STAMP_BITS : SIZE_W)-1:0] pick_key_i,
  output logic [((STAMP_BITS > SIZE_W) ? STAMP_BITS : SIZE_W)-1:0] key_o,
  output logic                                                  better_o
);

  localparam int unsigned KW = (STAMP_BITS > SIZE_W) ? STAMP_BITS : SIZE_W;

  logic [STAMP_BITS-1:0] age;

  assign age   = arrival_i - stamp_i;
  assign key_o = mode_i ? KW'(size_i) : KW'(age);

  always_comb begin
    if (!found_i) begin
      better_o = 1'b1;
    end else if (mode_i) begin
      better_o = key_o < pick_key_i;
    end else begin
      better_o = key_o > pick_key_i;
    end
  end

endmodule

// ----- rtl/request_slot_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// request_slot_scheduler_top
// Slot table of pending requests served oldest first or shortest job first.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result shows
// on the result ports for one cycle with done_o, and the receiver cannot hold
// it off. A put walks the valid bits one slot a cycle up to L, the usable
// slot limit, and stops at the first free slot; a get reads the slot memory
// one entry a cycle through a single compare unit over all L slots. busy
// drops in the cycle that done_o is shown, so the next command may follow.
// ----------------------------------------------------------------------------
module request_slot_scheduler_top import rss_pkg::*; #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned STAMP_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  input  logic                 start,
  output logic                 busy,
  input  logic                 func_i,
  input  logic [HANDLE_W-1:0]  handle_i,
  input  logic [SIZE_W-1:0]    job_size_i,
  output logic                 done_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [HANDLE_W-1:0]  handle_out_o,
  output logic [OCC_W-1:0]     occupancy_o
);

  localparam int unsigned IW = $clog2(SLOTS + 1);
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LW = (IW > OCC_W) ? IW : OCC_W;
  localparam int unsigned KW = (STAMP_BITS > SIZE_W) ? STAMP_BITS : SIZE_W;
  localparam int unsigned MW = HANDLE_W + SIZE_W + STAMP_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PUT  = 2'd1;
  localparam logic [1:0] ST_GET  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic                  mode_q;
  logic [OCC_W-1:0]      slots_q;
  logic [SLOTS-1:0]      valid_q, valid_d;
  logic [STAMP_BITS-1:0] arrival_q, arrival_d;
  logic [IW-1:0]         count_q, count_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [AW-1:0]         idx_a;
  logic                  rd_v_q, rd_v_d;
  logic [AW-1:0]         rd_idx_q, rd_idx_d;
  logic                  found_q, found_d;
  logic [KW-1:0]         pick_key_q, pick_key_d;
  logic [AW-1:0]         pick_idx_q, pick_idx_d;
  logic [HANDLE_W-1:0]   pick_handle_q, pick_handle_d;
  logic [HANDLE_W-1:0]   put_handle_q, put_handle_d;
  logic [SIZE_W-1:0]     put_size_q, put_size_d;
  logic                  done_q, done_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [HANDLE_W-1:0]   handle_out_q, handle_out_d;
  logic [OCC_W-1:0]      occ_q, occ_d;

  logic [MW-1:0]         mem_q [SLOTS];
  logic [MW-1:0]         rdata_q;
  logic                  mem_we, mem_re;
  logic [IW-1:0]         limit;
  logic [KW-1:0]         key;
  logic                  better;
  logic                  cfg_wr;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      slots_q <= SLOTS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MODE:  mode_q  <= pwdata[0];
        REG_SLOTS: slots_q <= pwdata[OCC_W-1:0];
        default:   mode_q  <= mode_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MODE:  prdata = PDATA_W'(mode_q);
      REG_SLOTS: prdata = PDATA_W'(slots_q);
      default:   prdata = '0;
    endcase
  end

  assign limit = (LW'(slots_q) > LW'(SLOTS)) ? IW'(SLOTS) : IW'(slots_q);
  assign idx_a = idx_q[AW-1:0];

  // slot memory: {handle, size, stamp}
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_a] <= {put_handle_q, put_size_q, arrival_q};
    end
    if (mem_re) begin
      rdata_q <= mem_q[idx_a];
    end
  end

  rss_pick_unit #(
    .STAMP_BITS (STAMP_BITS)
  ) u_pick (
    .mode_i     (mode_q),
    .found_i    (found_q),
    .arrival_i  (arrival_q),
    .stamp_i    (rdata_q[STAMP_BITS-1:0]),
    .size_i     (rdata_q[STAMP_BITS +: SIZE_W]),
    .pick_key_i (pick_key_q),
    .key_o      (key),
    .better_o   (better)
  );

  always_comb begin
    state_d       = state_q;
    valid_d       = valid_q;
    arrival_d     = arrival_q;
    count_d       = count_q;
    idx_d         = idx_q;
    rd_v_d        = 1'b0;
    rd_idx_d      = rd_idx_q;
    found_d       = found_q;
    pick_key_d    = pick_key_q;
    pick_idx_d    = pick_idx_q;
    pick_handle_d = pick_handle_q;
    put_handle_d  = put_handle_q;
    put_size_d    = put_size_q;
    done_d        = 1'b0;
    status_d      = status_q;
    handle_out_d  = handle_out_q;
    occ_d         = occ_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          put_handle_d = handle_i;
          put_size_d   = job_size_i;
          idx_d        = '0;
          found_d      = 1'b0;
          state_d      = (func_i == FUNC_GET) ? ST_GET : ST_PUT;
        end
      end
      ST_PUT: begin
        if (idx_q == limit) begin
          done_d       = 1'b1;
          status_d     = STATUS_PUT_FULL;
          handle_out_d = '0;
          occ_d        = OCC_W'(count_q);
          state_d      = ST_IDLE;
        end else if (!valid_q[idx_a]) begin
          mem_we         = 1'b1;
          valid_d[idx_a] = 1'b1;
          arrival_d      = arrival_q + STAMP_BITS'(1);
          count_d        = count_q + IW'(1);
          done_d         = 1'b1;
          status_d       = STATUS_PUT_OK;
          handle_out_d   = '0;
          occ_d          = OCC_W'(count_q + IW'(1));
          state_d        = ST_IDLE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_GET: begin
        if (idx_q != limit) begin
          mem_re   = 1'b1;
          rd_v_d   = 1'b1;
          rd_idx_d = idx_a;
          idx_d    = idx_q + IW'(1);
        end
        if (rd_v_q && valid_q[rd_idx_q] && better) begin
          found_d       = 1'b1;
          pick_key_d    = key;
          pick_idx_d    = rd_idx_q;
          pick_handle_d = rdata_q[MW-1 -: HANDLE_W];
        end
        if (idx_q == limit && !rd_v_q) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (found_q) begin
            valid_d[pick_idx_q] = 1'b0;
            count_d             = count_q - IW'(1);
            status_d            = STATUS_GET_OK;
            handle_out_d        = pick_handle_q;
            occ_d               = OCC_W'(count_q - IW'(1));
          end else begin
            status_d     = STATUS_GET_EMPTY;
            handle_out_d = '0;
            occ_d        = OCC_W'(count_q);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      arrival_q <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      rd_v_q    <= 1'b0;
      found_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      arrival_q <= arrival_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      rd_v_q    <= rd_v_d;
      found_q   <= found_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q      <= rd_idx_d;
    pick_key_q    <= pick_key_d;
    pick_idx_q    <= pick_idx_d;
    pick_handle_q <= pick_handle_d;
    put_handle_q  <= put_handle_d;
    put_size_q    <= put_size_d;
    status_q      <= status_d;
    handle_out_q  <= handle_out_d;
    occ_q         <= occ_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign handle_out_o = handle_out_q;
  assign occupancy_o  = occ_q;

  // checks
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("stored count differs from valid bits");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= int'(SLOTS))
    else $error("stored count above slot count");

  a_read_only_in_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> state_q == ST_GET)
    else $error("slot read outside a get scan");

  a_start_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not start the sequencer");

  a_done_only_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while sequencer busy");

endmodule
